FILE: src/stq_pkg.sv
// Types, codes and helpers shared by the trapezoidal stepper motion queue.
`timescale 1ns / 1ps
package stq_pkg;
	localparam int QUEUE_DEPTH = 8;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int RATE_W      = 24;
	localparam int SPEED_W     = 18;
	localparam int PERIOD_W    = 16;
	localparam int CNT_W       = $clog2(RATE_W + 1);

	localparam logic [SPEED_W-1:0] SPEED_MIN = SPEED_W'(3);
	localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(187500);
	localparam logic [RATE_W-1:0]  TICK_RATE_RESET = RATE_W'(187500);

	localparam logic [1:0] CMD_ENQUEUE = 2'd0;
	localparam logic [1:0] CMD_STEP    = 2'd1;
	localparam logic [1:0] CMD_ACCEL   = 2'd2;

	localparam logic [1:0] PH_ACCEL  = 2'd0;
	localparam logic [1:0] PH_CRUISE = 2'd1;
	localparam logic [1:0] PH_DECEL  = 2'd2;

	localparam logic [1:0] ST_NORMAL  = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_DROPPED = 2'd2;

	typedef struct packed {
		logic [1:0]         command;
		logic               is_wait;
		logic signed [31:0] steps;
		logic [23:0]        start_speed;
		logic [23:0]        accel;
		logic [31:0]        accel_length;
		logic [31:0]        decel_length;
		logic [7:0]         reply_tag;
	} in_item_t;

	typedef struct packed {
		logic               step_toggle;
		logic               direction;
		logic [15:0]        step_period;
		logic               period_load;
		logic [15:0]        accel_timer_period;
		logic               accel_load;
		logic [1:0]         queue_status;
		logic               done_res;
		logic               done_kind;
		logic signed [31:0] steps_taken;
		logic [7:0]         done_tag;
		logic [1:0]         phase;
	} out_item_t;

	function automatic logic [SPEED_W-1:0] clamp_rate(input logic [23:0] v);
		if (v < 24'(SPEED_MIN)) return SPEED_MIN;
		if (v > 24'(SPEED_MAX)) return SPEED_MAX;
		return v[SPEED_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
		if (i == IDX_W'(QUEUE_DEPTH - 1)) return '0;
		return i + 1'b1;
	endfunction
endpackage

FILE: src/stepper_trapezoid_motion_queue.sv
// Top level of the trapezoidal stepper motion queue with its block memory and period divider.
`timescale 1ns / 1ps
// Usage: requests enter on in_valid/in_stall/in_data and results leave on
// out_valid/out_stall/out_data; each request gives exactly one result.
// tick_rate is written through cfg_wen/cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce it.
// Move blocks live in one synchronous memory with a registered read. Every
// period comes from one restoring divider that makes one quotient bit per cycle.
// A step tick that starts no block, a full-queue enqueue, an accel tick
// in cruise and an unknown command do not use the divider. A step tick
// that starts a block and an accel tick that changes speed run one division.
// An enqueue runs one division, or two when the queue was empty, since
// that also computes the first step period.
// One request is worked at a time; in_stall is high from acceptance until
// the result has moved into the output register.
// A stalled result holds in the output register while the next request
// is already being worked.
// Reset empties the queue, clears position, speed and period, sets the
// phase to cruise and tick_rate to 187500.
module stepper_trapezoid_motion_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  stq_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output stq_pkg::out_item_t out_data,
	input  logic               cfg_wen,
	input  logic [23:0]        cfg_wdata
);
	import stq_pkg::*;

	typedef struct packed {
		logic [SPEED_W-1:0]  speed;
		logic [PERIOD_W-1:0] aper;
		logic [30:0]         length;
		logic [31:0]         accel_to;
		logic [31:0]         decel_from;
		logic                is_wait;
		logic                dir;
		logic                is_new;
		logic [7:0]          tag;
	} entry_t;

	typedef enum logic [2:0] {S_IDLE, S_CMD, S_TICK, S_DIV, S_OUT} state_t;
	typedef enum logic [1:0] {DV_ENQ_AP, DV_ENQ_SP, DV_SPEED} div_sel_t;

	state_t              state_q;
	div_sel_t            sel_q;
	in_item_t            req_q;
	out_item_t           res_q, out_q, out_next;
	logic                ovr_q, out_valid_q;
	logic [RATE_W-1:0]   tick_rate_q;
	logic [IDX_W-1:0]    head_q, tail_q;
	logic [31:0]         pos_q;
	logic [SPEED_W-1:0]  speed_q;
	logic [PERIOD_W-1:0] period_q;
	logic [1:0]          phase_q;
	logic                dir_q;

	// Divider registers: quo_q shifts the dividend out as quotient bits come in.
	logic [RATE_W:0]     rem_q;
	logic [RATE_W-1:0]   quo_q;
	logic [SPEED_W-1:0]  dsr_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [RATE_W:0]     rem_sh, rem_n;
	logic [RATE_W-1:0]   quo_n;
	logic                div_last;

	entry_t              mem_q [QUEUE_DEPTH];
	entry_t              rd_q, mem_wd;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_wa;

	logic                q_empty, q_full, out_free;
	logic [SPEED_W-1:0]  sp_clamped, ac_clamped;
	logic [31:0]         len_abs;
	logic [31:0]         pos_inc;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign q_empty    = (head_q == tail_q);
	assign q_full     = (next_slot(head_q) == tail_q);
	assign sp_clamped = clamp_rate(req_q.start_speed);
	assign ac_clamped = clamp_rate(req_q.accel);
	assign len_abs    = req_q.steps[31] ? (32'd0 - 32'(req_q.steps)) : 32'(req_q.steps);
	assign pos_inc    = pos_q + 32'd1;

	always_comb begin
		out_next           = res_q;
		out_next.direction = dir_q;
		out_next.phase     = phase_q;
		if (!ovr_q) begin
			out_next.step_period = period_q;
		end
	end

	always_comb begin
		rem_sh = {rem_q[RATE_W-1:0], quo_q[RATE_W-1]};
		if (rem_sh >= (RATE_W+1)'(dsr_q)) begin
			rem_n = rem_sh - (RATE_W+1)'(dsr_q);
			quo_n = {quo_q[RATE_W-2:0], 1'b1};
		end else begin
			rem_n = rem_sh;
			quo_n = {quo_q[RATE_W-2:0], 1'b0};
		end
		if (dsr_q == '0) quo_n = '0;
		div_last = (cnt_q == CNT_W'(1));
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = head_q;
		mem_wd = rd_q;
		if (state_q == S_TICK && (32'(rd_q.length) > pos_q) && rd_q.is_new) begin
			mem_we        = 1'b1;
			mem_wa        = tail_q;
			mem_wd.is_new = 1'b0;
		end else if (state_q == S_DIV && div_last && sel_q == DV_ENQ_AP) begin
			mem_we            = 1'b1;
			mem_wa            = head_q;
			mem_wd.speed      = sp_clamped;
			mem_wd.aper       = quo_n[PERIOD_W-1:0];
			mem_wd.length     = (len_abs > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : len_abs[30:0];
			mem_wd.accel_to   = req_q.accel_length;
			mem_wd.decel_from = req_q.decel_length;
			mem_wd.is_wait    = req_q.is_wait;
			mem_wd.dir        = !req_q.steps[31];
			mem_wd.is_new     = 1'b1;
			mem_wd.tag        = req_q.reply_tag;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rd_q <= mem_q[tail_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_q       <= DV_SPEED;
			req_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			tick_rate_q <= TICK_RATE_RESET;
			head_q      <= '0;
			tail_q      <= '0;
			pos_q       <= '0;
			speed_q     <= '0;
			period_q    <= '0;
			phase_q     <= PH_CRUISE;
			dir_q       <= 1'b0;
			out_valid_q <= 1'b0;
			rem_q       <= '0;
			quo_q       <= '0;
			dsr_q       <= '0;
			cnt_q       <= '0;
			ovr_q       <= 1'b0;
		end else begin
			if (cfg_wen) begin
				tick_rate_q <= cfg_wdata;
			end
			if (state_q == S_OUT && out_free) begin
				out_q       <= out_next;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= in_data;
						res_q   <= '0;
						ovr_q   <= 1'b0;
						state_q <= S_CMD;
					end
				end
				S_CMD: begin
					rem_q <= '0;
					quo_q <= tick_rate_q;
					cnt_q <= CNT_W'(RATE_W);
					case (req_q.command)
						CMD_ENQUEUE: begin
							if (q_full) begin
								res_q.queue_status <= ST_DROPPED;
								state_q <= S_OUT;
							end else begin
								dsr_q   <= ac_clamped;
								sel_q   <= DV_ENQ_AP;
								state_q <= S_DIV;
							end
						end
						CMD_STEP: begin
							if (q_empty) begin
								res_q.queue_status <= ST_EMPTY;
								state_q <= S_OUT;
							end else begin
								state_q <= S_TICK;
							end
						end
						CMD_ACCEL: begin
							if (phase_q == PH_ACCEL) begin
								speed_q <= (speed_q >= SPEED_MAX) ? SPEED_MAX : speed_q + 1'b1;
								dsr_q   <= (speed_q >= SPEED_MAX) ? SPEED_MAX : speed_q + 1'b1;
								res_q.period_load <= 1'b1;
								sel_q   <= DV_SPEED;
								state_q <= S_DIV;
							end else if (phase_q == PH_DECEL) begin
								speed_q <= (speed_q <= SPEED_MIN) ? SPEED_MIN : speed_q - 1'b1;
								dsr_q   <= (speed_q <= SPEED_MIN) ? SPEED_MIN : speed_q - 1'b1;
								res_q.period_load <= 1'b1;
								sel_q   <= DV_SPEED;
								state_q <= S_DIV;
							end else begin
								state_q <= S_OUT;
							end
						end
						default: begin
							state_q <= S_OUT;
						end
					endcase
				end
				S_TICK: begin
					if (32'(rd_q.length) > pos_q) begin
						if (rd_q.is_new) begin
							speed_q  <= rd_q.speed;
							dsr_q    <= rd_q.speed;
							dir_q    <= rd_q.dir;
							res_q.period_load        <= 1'b1;
							res_q.accel_load         <= 1'b1;
							res_q.accel_timer_period <= rd_q.aper;
							sel_q    <= DV_SPEED;
							state_q  <= S_DIV;
						end else begin
							state_q  <= S_OUT;
						end
						res_q.step_toggle <= !rd_q.is_wait;
						pos_q <= pos_inc;
						if (pos_inc < rd_q.accel_to) begin
							phase_q <= PH_ACCEL;
						end else if (pos_inc > rd_q.decel_from) begin
							phase_q <= PH_DECEL;
						end else begin
							phase_q <= PH_CRUISE;
						end
					end else begin
						res_q.done_res  <= 1'b1;
						res_q.done_tag  <= rd_q.tag;
						res_q.done_kind <= !rd_q.is_wait;
						if (!rd_q.is_wait) begin
							res_q.steps_taken <= rd_q.dir ? 32'(rd_q.length)
							                               : 32'd0 - 32'(rd_q.length);
						end
						tail_q  <= next_slot(tail_q);
						pos_q   <= '0;
						state_q <= S_OUT;
					end
				end
				S_DIV: begin
					if (!div_last) begin
						rem_q <= rem_n;
						quo_q <= quo_n;
						cnt_q <= cnt_q - 1'b1;
					end else begin
						case (sel_q)
							DV_ENQ_AP: begin
								head_q <= next_slot(head_q);
								if (q_empty) begin
									// First block into an empty queue restarts both timers.
									res_q.accel_timer_period <= quo_n[PERIOD_W-1:0];
									res_q.accel_load         <= 1'b1;
									res_q.period_load        <= 1'b1;
									ovr_q   <= 1'b1;
									rem_q   <= '0;
									quo_q   <= tick_rate_q;
									cnt_q   <= CNT_W'(RATE_W);
									dsr_q   <= sp_clamped;
									sel_q   <= DV_ENQ_SP;
									state_q <= S_DIV;
								end else begin
									state_q <= S_OUT;
								end
							end
							DV_ENQ_SP: begin
								res_q.step_period <= quo_n[PERIOD_W-1:0];
								state_q <= S_OUT;
							end
							default: begin
								period_q <= quo_n[PERIOD_W-1:0];
								state_q  <= S_OUT;
							end
						endcase
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// An empty queue never carries a partial position.
	a_empty_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == tail_q) |-> (pos_q == '0))
		else $error("position nonzero with empty queue");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (cnt_q != '0))
		else $error("divider running with zero count");

	a_speed_max: assert property (@(posedge clk) disable iff (!arst_n)
		speed_q <= SPEED_MAX)
		else $error("speed above limit");

	a_mem_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_TICK || state_q == S_DIV))
		else $error("memory written outside block update");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !out_free) |=> (state_q == S_OUT))
		else $error("result left while output register busy");
endmodule
